>>> rtl/htok_pkg.sv
`timescale 1ns / 1ps

package htok_pkg;

	typedef enum logic [2:0] {
		PH_METHOD  = 3'd0,
		PH_URI     = 3'd1,
		PH_VERSION = 3'd2,
		PH_HNAME   = 3'd3,
		PH_HSKIP   = 3'd4,
		PH_HVALUE  = 3'd5,
		PH_DONE    = 3'd6
	} phase_t;

	localparam logic [2:0] KIND_METHOD  = 3'd0;
	localparam logic [2:0] KIND_URI     = 3'd1;
	localparam logic [2:0] KIND_VERSION = 3'd2;
	localparam logic [2:0] KIND_HNAME   = 3'd3;
	localparam logic [2:0] KIND_HVALUE  = 3'd4;
	localparam logic [2:0] KIND_EOH     = 3'd5;

	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_BAD_VERSION = 2'd1;
	localparam logic [1:0] ST_MALFORMED   = 2'd2;

	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3a;

	localparam logic [3:0] VER_MINOR_IDX = 4'd7;
	localparam logic [3:0] VER_LEN       = 4'd8;
	localparam logic [3:0] VER_IDX_MAX   = 4'd15;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       start_flag;
		logic       end_flag;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic [2:0] field_kind;
		logic       field_last;
		logic [1:0] status;
	} out_item_t;

	typedef struct packed {
		phase_t     phase;
		logic [3:0] vidx;
		logic [1:0] vmatch;
		logic       held_cr;
		logic       line_empty;
	} state_t;

	localparam state_t STATE_RESET = '{
		phase:      PH_METHOD,
		vidx:       4'd0,
		vmatch:     2'b11,
		held_cr:    1'b0,
		line_empty: 1'b0
	};

	typedef struct packed {
		state_t    st;
		logic      emit;
		out_item_t res;
	} step_t;

	// up to two results of one input byte, packed from the front
	typedef struct packed {
		logic [1:0] cnt;
		out_item_t  r0;
		out_item_t  r1;
	} res_pair_t;

	// "HTTP/1." prefix
	function automatic logic [7:0] ver_char(input logic [2:0] idx);
		logic [7:0] ch;
		unique case (idx)
			3'd0:    ch = 8'h48;
			3'd1:    ch = 8'h54;
			3'd2:    ch = 8'h54;
			3'd3:    ch = 8'h50;
			3'd4:    ch = 8'h2f;
			3'd5:    ch = 8'h31;
			3'd6:    ch = 8'h2e;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic out_item_t mk_byte(input logic [7:0] b, input logic [2:0] kind);
		out_item_t r;
		r.out_byte   = b;
		r.has_byte   = 1'b1;
		r.field_kind = kind;
		r.field_last = 1'b0;
		r.status     = ST_OK;
		return r;
	endfunction

	function automatic out_item_t mk_mark(input logic [2:0] kind, input logic [1:0] st);
		out_item_t r;
		r.out_byte   = 8'h00;
		r.has_byte   = 1'b0;
		r.field_kind = kind;
		r.field_last = 1'b1;
		r.status     = st;
		return r;
	endfunction

	function automatic logic [2:0] line_kind(input phase_t ph);
		return (ph == PH_METHOD) ? KIND_METHOD : KIND_URI;
	endfunction

	function automatic step_t end_version(input state_t s);
		step_t o;
		logic  ok;
		o      = '{st: s, emit: 1'b1, res: '0};
		ok     = (s.vidx == VER_LEN) && (s.vmatch != 2'b00);
		o.res  = mk_mark(KIND_VERSION, ok ? ST_OK : ST_BAD_VERSION);
		if (ok) begin
			o.st.phase      = PH_HNAME;
			o.st.line_empty = 1'b1;
		end else begin
			o.st.phase = PH_DONE;
		end
		return o;
	endfunction

	function automatic step_t feed(input state_t s, input logic [7:0] c, input logic crb);
		step_t o;
		o = '{st: s, emit: 1'b0, res: '0};
		unique case (s.phase)
			PH_METHOD, PH_URI: begin
				o.emit = 1'b1;
				if (c == CH_SP) begin
					o.res      = mk_mark(line_kind(s.phase), ST_OK);
					o.st.phase = (s.phase == PH_METHOD) ? PH_URI : PH_VERSION;
				end else if (c == CH_LF) begin
					o.res      = mk_mark(line_kind(s.phase), ST_BAD_VERSION);
					o.st.phase = PH_DONE;
				end else begin
					o.res = mk_byte(c, line_kind(s.phase));
				end
			end
			PH_VERSION: begin
				if (c == CH_LF) begin
					o = end_version(s);
				end else begin
					if (s.vidx < VER_MINOR_IDX) begin
						if (c != ver_char(s.vidx[2:0]))
							o.st.vmatch = 2'b00;
					end else if (s.vidx == VER_MINOR_IDX) begin
						o.st.vmatch = s.vmatch & {c == 8'h31, c == 8'h30};
					end else begin
						o.st.vmatch = 2'b00;
					end
					if (s.vidx < VER_IDX_MAX)
						o.st.vidx = s.vidx + 4'd1;
					o.emit = 1'b1;
					o.res  = mk_byte(c, KIND_VERSION);
				end
			end
			PH_HNAME: begin
				o.emit = 1'b1;
				if (c == CH_LF) begin
					if (s.line_empty && crb) begin
						o.res      = mk_mark(KIND_EOH, ST_OK);
						o.st.phase = PH_DONE;
					end else begin
						o.res           = mk_mark(KIND_HNAME, ST_MALFORMED);
						o.st.line_empty = 1'b1;
					end
				end else if (c == CH_COLON) begin
					o.res           = mk_mark(KIND_HNAME, ST_OK);
					o.st.phase      = PH_HSKIP;
					o.st.line_empty = 1'b0;
				end else begin
					o.res = mk_byte((c >= 8'h41 && c <= 8'h5a) ? (c | 8'h20) : c,
						KIND_HNAME);
					o.st.line_empty = 1'b0;
				end
			end
			PH_HSKIP, PH_HVALUE: begin
				if (c == CH_LF) begin
					o.emit          = 1'b1;
					o.res           = mk_mark(KIND_HVALUE, ST_OK);
					o.st.phase      = PH_HNAME;
					o.st.line_empty = 1'b1;
				end else if (s.phase == PH_HSKIP) begin
					o.st.phase = PH_HVALUE;
				end else begin
					o.emit = 1'b1;
					o.res  = mk_byte(c, KIND_HVALUE);
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	function automatic step_t close_end(input state_t s);
		step_t o;
		o = '{st: s, emit: 1'b0, res: '0};
		unique case (s.phase)
			PH_METHOD, PH_URI: begin
				o.emit = 1'b1;
				o.res  = mk_mark(line_kind(s.phase), ST_BAD_VERSION);
			end
			PH_VERSION: o = end_version(s);
			PH_HNAME: begin
				o.emit = 1'b1;
				o.res  = s.line_empty ? mk_mark(KIND_EOH, ST_OK)
					: mk_mark(KIND_HNAME, ST_MALFORMED);
			end
			PH_HSKIP, PH_HVALUE: begin
				o.emit = 1'b1;
				o.res  = mk_mark(KIND_HVALUE, ST_OK);
			end
			default: ;
		endcase
		o.st.phase = PH_DONE;
		return o;
	endfunction

endpackage

>>> rtl/http_request_header_tokenizer.sv
`timescale 1ns / 1ps

// Takes one request byte per cycle while not stalled and returns tagged field
// bytes and field-end markers. A byte is registered on transfer and parsed from
// that register into a two-entry result buffer. Most bytes give at most one
// result and stream at one byte per cycle while the output is ready; a byte that
// gives two results (a field byte after a lone CR, or a last byte that also
// closes the open field) holds the input while the result buffer drains. Bytes
// that give no result still pass through the input register.
module http_request_header_tokenizer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  htok_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output htok_pkg::out_item_t out_item
);
	import htok_pkg::*;

	logic      valid_s1;
	in_item_t  item_s1;
	state_t    state_q;
	state_t    state_nxt;
	res_pair_t res;
	logic      can_load;
	logic      adv;

	assign adv      = valid_s1 && can_load;
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q  <= STATE_RESET;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (adv)
				state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_s1 <= in_item;
	end

	htok_core u_core (
		.state     (state_q),
		.item      (item_s1),
		.state_nxt (state_nxt),
		.res       (res)
	);

	htok_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv),
		.res       (res),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

>>> rtl/htok_core.sv
`timescale 1ns / 1ps

module htok_core (
	input  htok_pkg::state_t    state,
	input  htok_pkg::in_item_t  item,
	output htok_pkg::state_t    state_nxt,
	output htok_pkg::res_pair_t res
);
	import htok_pkg::*;

	state_t     s0;
	logic       cr;
	logic       is_cr;
	logic       is_lf;
	logic       en0;
	logic [7:0] ch0;
	logic       crb0;
	logic       sec_feed;
	logic       sec_close;
	logic       held_nxt;
	step_t      fa;
	step_t      fb;

	always_comb begin
		s0         = item.start_flag ? STATE_RESET : state;
		cr         = s0.held_cr;
		s0.held_cr = 1'b0;
		is_cr      = (item.in_byte == CH_CR);
		is_lf      = (item.in_byte == CH_LF);
		en0        = cr;
		ch0        = CH_CR;
		crb0       = 1'b0;
		sec_feed   = 1'b0;
		sec_close  = 1'b0;
		held_nxt   = 1'b0;
		if (item.end_flag) begin
			en0       = 1'b1;
			ch0       = (is_cr || is_lf) ? CH_LF : item.in_byte;
			crb0      = (is_cr || is_lf) && (cr || is_cr);
			sec_close = 1'b1;
		end else if (is_cr) begin
			held_nxt = 1'b1;
		end else if (is_lf) begin
			en0  = 1'b1;
			ch0  = CH_LF;
			crb0 = cr;
		end else begin
			sec_feed = 1'b1;
		end
	end

	always_comb begin
		fa = en0 ? feed(s0, ch0, crb0) : '{st: s0, emit: 1'b0, res: '0};
		if (sec_close)
			fb = close_end(fa.st);
		else if (sec_feed)
			fb = feed(fa.st, item.in_byte, 1'b0);
		else
			fb = '{st: fa.st, emit: 1'b0, res: '0};
	end

	always_comb begin
		state_nxt         = fb.st;
		state_nxt.held_cr = held_nxt;
		res.cnt           = {1'b0, fa.emit} + {1'b0, fb.emit};
		res.r0            = fa.emit ? fa.res : fb.res;
		res.r1            = fb.res;
	end

endmodule

>>> rtl/htok_outbuf.sv
`timescale 1ns / 1ps

module htok_outbuf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  htok_pkg::res_pair_t res,
	output logic                can_load,
	output logic                out_valid,
	input  logic                out_ready,
	output htok_pkg::out_item_t out_item
);
	import htok_pkg::*;

	logic [1:0] cnt_q;
	out_item_t  head_q;
	out_item_t  tail_q;
	logic       pop;

	assign out_valid = (cnt_q != 2'd0);
	assign out_item  = head_q;
	assign pop       = out_valid && out_ready;
	assign can_load  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= res.cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			head_q <= res.r0;
			tail_q <= res.r1;
		end else if (pop) begin
			head_q <= tail_q;
		end
	end

endmodule

>>> rtl/htok_checker.sv
`timescale 1ns / 1ps

module htok_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input htok_pkg::in_item_t  in_item,
	input logic                out_valid,
	input logic                out_ready,
	input htok_pkg::out_item_t out_item
);
	import htok_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// a marker closes a field and carries no byte
	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.has_byte |-> out_item.field_last && out_item.out_byte == 8'h00)
		else $error("marker malformed");

	// a field byte is never last and always ok
	a_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.has_byte |->
			!out_item.field_last && out_item.status == ST_OK && out_item.field_kind != KIND_EOH)
		else $error("field byte malformed");

	// a malformed-line status only closes a header name
	a_malformed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status == ST_MALFORMED |-> out_item.field_kind == KIND_HNAME)
		else $error("malformed status on wrong field");

endmodule

bind http_request_header_tokenizer htok_checker u_htok_checker (.*);
